[src/olist_pkg.sv]
package olist_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int FUNC_W = 2;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

[src/olist_ram.sv]
module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/ordered_list_insert_delete_search.sv]
// Ordered list of up to DEPTH words held in a dual-port RAM (one write, one registered read
// per cycle) plus an entry count. Each transfer on the s_ channel carries one operation
// (insert, delete, get, locate) and yields exactly one transfer on the m_ channel. The
// block works on one operation at a time: s_ready is high only while it is idle, and an
// accepted item may wait in the result register while the next one is taken. Entries are
// moved or compared one per cycle through the RAM read port: an insert at position p moves
// entries p..count one place up, last first, then writes the item (an append only writes),
// a delete or get reads from p upward, a locate compares from entry 1 until a match or
// the end; a rejected operation goes straight to the done state, where a result waits while
// m_valid waits on m_ready. No clearing pass follows reset: words past the count go unused.
module ordered_list_insert_delete_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [olist_pkg::FUNC_W-1:0]  s_func,
    input  logic [olist_pkg::POS_W-1:0]   s_position,
    input  logic [olist_pkg::VAL_W-1:0]   s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [olist_pkg::STAT_W-1:0]  m_status,
    output logic [olist_pkg::VAL_W-1:0]   m_read_value,
    output logic [olist_pkg::POS_W-1:0]   m_found_position,
    output logic [olist_pkg::POS_W-1:0]   m_entry_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_END,
        S_PUT,
        S_DN,
        S_DN_END,
        S_SCAN,
        S_SCAN_END,
        S_DONE
    } state_t;

    state_t                                 state_reg, state_next;
    logic [olist_pkg::CNT_W-1:0]            count_reg, count_next;
    olist_pkg::func_t                       func_reg, func_next;
    logic [olist_pkg::ADDR_W-1:0]           ptr_reg, ptr_next;
    logic [olist_pkg::ADDR_W-1:0]           end_reg, end_next;
    logic [olist_pkg::DATA_WIDTH-1:0]       item_reg, item_next;
    logic                                   pend_valid_reg, pend_valid_next;
    logic [olist_pkg::ADDR_W-1:0]           pend_addr_reg, pend_addr_next;
    logic                                   first_reg, first_next;
    logic                                   cap_reg, cap_next;
    olist_pkg::status_t                     res_status_reg, res_status_next;
    logic [olist_pkg::VAL_W-1:0]            res_value_reg, res_value_next;
    logic [olist_pkg::POS_W-1:0]            res_found_reg, res_found_next;
    logic                                   m_valid_reg, m_valid_next;
    olist_pkg::status_t                     m_status_reg, m_status_next;
    logic [olist_pkg::VAL_W-1:0]            m_read_value_reg, m_read_value_next;
    logic [olist_pkg::POS_W-1:0]            m_found_position_reg, m_found_position_next;
    logic [olist_pkg::POS_W-1:0]            m_entry_count_reg, m_entry_count_next;

    logic                                   ram_we;
    logic [olist_pkg::ADDR_W-1:0]           ram_waddr;
    logic [olist_pkg::DATA_WIDTH-1:0]       ram_wdata;
    logic [olist_pkg::ADDR_W-1:0]           ram_raddr;
    logic [olist_pkg::DATA_WIDTH-1:0]       ram_rdata;

    logic [olist_pkg::CMP_W-1:0]            pos_x;
    logic [olist_pkg::CMP_W-1:0]            cnt_x;
    logic                                   match;

    olist_ram #(
        .WIDTH (olist_pkg::DATA_WIDTH),
        .DEPTH (olist_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_x = olist_pkg::CMP_W'(s_position);
    assign cnt_x = olist_pkg::CMP_W'(count_reg);
    assign match = (ram_rdata == item_reg);

    always_comb begin
        state_next            = state_reg;
        count_next            = count_reg;
        func_next             = func_reg;
        ptr_next              = ptr_reg;
        end_next              = end_reg;
        item_next             = item_reg;
        pend_valid_next       = pend_valid_reg;
        pend_addr_next        = pend_addr_reg;
        first_next            = first_reg;
        cap_next              = cap_reg;
        res_status_next       = res_status_reg;
        res_value_next        = res_value_reg;
        res_found_next        = res_found_reg;
        m_valid_next          = m_valid_reg;
        m_status_next         = m_status_reg;
        m_read_value_next     = m_read_value_reg;
        m_found_position_next = m_found_position_reg;
        m_entry_count_next    = m_entry_count_reg;
        ram_we                = 1'b0;
        ram_waddr             = pend_addr_reg;
        ram_wdata             = ram_rdata;
        ram_raddr             = ptr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next       = olist_pkg::func_t'(s_func);
                    item_next       = olist_pkg::DATA_WIDTH'(s_item_value);
                    res_status_next = olist_pkg::ST_OK;
                    res_value_next  = '0;
                    res_found_next  = '0;
                    pend_valid_next = 1'b0;
                    cap_next        = 1'b0;
                    first_next      = 1'b1;
                    unique case (olist_pkg::func_t'(s_func))
                        olist_pkg::OP_INSERT: begin
                            if (pos_x == '0 || pos_x > cnt_x + olist_pkg::CMP_W'(1)) begin
                                res_status_next = olist_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end else if (count_reg == olist_pkg::CNT_W'(olist_pkg::DEPTH)) begin
                                res_status_next = olist_pkg::ST_FULL;
                                state_next      = S_DONE;
                            end else begin
                                end_next = olist_pkg::ADDR_W'(pos_x - olist_pkg::CMP_W'(1));
                                if (pos_x - olist_pkg::CMP_W'(1) == cnt_x) begin
                                    state_next = S_PUT;
                                end else begin
                                    ptr_next   = olist_pkg::ADDR_W'(cnt_x - olist_pkg::CMP_W'(1));
                                    state_next = S_UP;
                                end
                            end
                        end
                        olist_pkg::OP_DELETE,
                        olist_pkg::OP_GET: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                res_status_next = olist_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                ptr_next = olist_pkg::ADDR_W'(pos_x - olist_pkg::CMP_W'(1));
                                if (olist_pkg::func_t'(s_func) == olist_pkg::OP_DELETE) begin
                                    end_next = olist_pkg::ADDR_W'(cnt_x - olist_pkg::CMP_W'(1));
                                end else begin
                                    end_next = olist_pkg::ADDR_W'(pos_x - olist_pkg::CMP_W'(1));
                                end
                                state_next = S_DN;
                            end
                        end
                        olist_pkg::OP_LOCATE: begin
                            if (count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                ptr_next   = '0;
                                end_next   = olist_pkg::ADDR_W'(cnt_x - olist_pkg::CMP_W'(1));
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // read downward, write each word one place up
            S_UP: begin
                ram_we          = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = ptr_reg + olist_pkg::ADDR_W'(1);
                if (ptr_reg == end_reg) begin
                    state_next = S_UP_END;
                end else begin
                    ptr_next = ptr_reg - olist_pkg::ADDR_W'(1);
                end
            end

            S_UP_END: begin
                ram_we          = pend_valid_reg;
                pend_valid_next = 1'b0;
                state_next      = S_PUT;
            end

            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = end_reg;
                ram_wdata  = item_reg;
                count_next = count_reg + olist_pkg::CNT_W'(1);
                state_next = S_DONE;
            end

            // read upward, capture the first word, write the rest one place down
            S_DN: begin
                ram_we          = pend_valid_reg;
                if (cap_reg) begin
                    res_value_next = olist_pkg::VAL_W'(ram_rdata);
                end
                cap_next        = first_reg;
                first_next      = 1'b0;
                pend_valid_next = !first_reg;
                pend_addr_next  = ptr_reg - olist_pkg::ADDR_W'(1);
                if (ptr_reg == end_reg) begin
                    state_next = S_DN_END;
                end else begin
                    ptr_next = ptr_reg + olist_pkg::ADDR_W'(1);
                end
            end

            S_DN_END: begin
                ram_we = pend_valid_reg;
                if (cap_reg) begin
                    res_value_next = olist_pkg::VAL_W'(ram_rdata);
                end
                cap_next        = 1'b0;
                pend_valid_next = 1'b0;
                if (func_reg == olist_pkg::OP_DELETE) begin
                    count_next = count_reg - olist_pkg::CNT_W'(1);
                end
                state_next = S_DONE;
            end

            S_SCAN: begin
                pend_valid_next = 1'b1;
                pend_addr_next  = ptr_reg;
                if (pend_valid_reg && match) begin
                    res_found_next  = olist_pkg::POS_W'(olist_pkg::CNT_W'(pend_addr_reg)
                                                        + olist_pkg::CNT_W'(1));
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                end else if (ptr_reg == end_reg) begin
                    state_next = S_SCAN_END;
                end else begin
                    ptr_next = ptr_reg + olist_pkg::ADDR_W'(1);
                end
            end

            S_SCAN_END: begin
                pend_valid_next = 1'b0;
                if (match) begin
                    res_found_next = olist_pkg::POS_W'(olist_pkg::CNT_W'(pend_addr_reg)
                                                       + olist_pkg::CNT_W'(1));
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_status_next         = res_status_reg;
                    m_read_value_next     = res_value_reg;
                    m_found_position_next = res_found_reg;
                    m_entry_count_next    = olist_pkg::POS_W'(count_reg);
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            first_reg      <= 1'b0;
            cap_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            first_reg      <= first_next;
            cap_reg        <= cap_next;
            m_valid_reg    <= m_valid_next;
        end
        func_reg             <= func_next;
        ptr_reg              <= ptr_next;
        end_reg              <= end_next;
        item_reg             <= item_next;
        pend_addr_reg        <= pend_addr_next;
        res_status_reg       <= res_status_next;
        res_value_reg        <= res_value_next;
        res_found_reg        <= res_found_next;
        m_status_reg         <= m_status_next;
        m_read_value_reg     <= m_read_value_next;
        m_found_position_reg <= m_found_position_next;
        m_entry_count_reg    <= m_entry_count_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_position_reg;
    assign m_entry_count    = m_entry_count_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("transfer accepted but sequencer stayed idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg != S_IDLE && state_reg != S_DONE
                   && state_reg != S_SCAN && state_reg != S_SCAN_END)
        else $error("RAM written outside a move or put");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg == $past(count_reg)
                           || count_reg == $past(count_reg) + olist_pkg::CNT_W'(1)
                           || count_reg == $past(count_reg) - olist_pkg::CNT_W'(1))
        else $error("entry count moved by more than one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != olist_pkg::ST_OK
            |-> m_read_value_reg == '0 && m_found_position_reg == '0)
        else $error("error result carries data");
`endif

endmodule
